// ----- rtl/core/sha_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies; used by sha256_stream_hasher.
package sha_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;

  // Request kinds carried on the input tuser bit
  localparam logic REQ_ABSORB = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // Padding marker byte and the byte offset where the length field starts
  localparam byte_t      PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  // Initial hash values H0..H7
  localparam word_t START_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants
  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Upper-case sigma functions of the round
  function automatic word_t big_sig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Lower-case sigma functions of the message schedule
  function automatic word_t sml_sig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t sml_sig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ----- rtl/core/sha256_stream_hasher.sv -----
// SHA-256 stream hasher: one shared round unit under a small sequencer.
// Depends on sha_pkg (types, round constants, sigma functions).
//
// Absorb items are accepted one per cycle while idle; the item that fills the
// 64-byte block also starts compression, which runs one round per cycle
// through a single round unit and then folds into the chaining state, after
// which the next item can be accepted. A finish item pads in its accepting
// cycle, then compresses one block, or two blocks when 56 or more bytes were
// pending, before the first digest word is offered. The digest then goes out
// as eight items, one per cycle while out_tready is high. in_tready is low
// from the start of a compression until the fold of an absorbed block ends,
// or after a finish until the last digest word is taken. The block buffer
// doubles as the 16-word message schedule window.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FOLD  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [5:0]      fill_r, fill_nxt;
  logic [63:0]     msg_bits_r, msg_bits_nxt;
  logic [63:0]     total_r, total_nxt;
  logic [5:0]      rnd_r, rnd_nxt;
  logic [2:0]      widx_r, widx_nxt;
  logic            fin_r, fin_nxt;        // current compression belongs to a finish
  logic            two_blk_r, two_blk_nxt; // a length-only block is still to come
  sha_pkg::word_t  chain_r [8];
  sha_pkg::word_t  chain_nxt [8];
  sha_pkg::word_t  work_r [8];
  sha_pkg::word_t  work_nxt [8];
  sha_pkg::word_t  win_r [16];
  sha_pkg::word_t  win_nxt [16];

  logic            in_acc, out_acc;
  logic [63:0]     total_now;
  sha_pkg::word_t  t1, t2, w_new;
  sha_pkg::word_t  fold_sum [8];

  assign in_acc  = in_tvalid & in_tready;
  assign out_acc = out_tvalid & out_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = chain_r[widx_r];
  assign out_tuser  = widx_r;
  assign out_tlast  = (widx_r == 3'd7);

  // Message length in bits including the pending tail
  assign total_now = msg_bits_r + {55'd0, fill_r, 3'b000};

  // Round unit
  always_comb begin
    t1 = work_r[7] + sha_pkg::big_sig1(work_r[4])
       + ((work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]))
       + sha_pkg::ROUND_K[rnd_r] + win_r[0];
    t2 = sha_pkg::big_sig0(work_r[0])
       + ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]));
    w_new = win_r[0] + sha_pkg::sml_sig0(win_r[1]) + win_r[9] + sha_pkg::sml_sig1(win_r[14]);
  end

  // Chaining update
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      fold_sum[i] = chain_r[i] + work_r[i];
    end
  end

  // Sequencer and datapath next state
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    msg_bits_nxt = msg_bits_r;
    total_nxt    = total_r;
    rnd_nxt      = rnd_r;
    widx_nxt     = widx_r;
    fin_nxt      = fin_r;
    two_blk_nxt  = two_blk_r;
    chain_nxt    = chain_r;
    work_nxt     = work_r;
    win_nxt      = win_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_tuser[0] == sha_pkg::REQ_ABSORB)) begin
          // Store the byte, big-endian within its word
          for (int w = 0; w < 16; w++) begin
            for (int b = 0; b < 4; b++) begin
              if ((fill_r[5:2] == w[3:0]) && (fill_r[1:0] == b[1:0])) begin
                win_nxt[w][(3 - b) * 8 +: 8] = in_tdata;
              end
            end
          end
          fill_nxt = fill_r + 6'd1;
          if (fill_r == 6'd63) begin
            msg_bits_nxt = msg_bits_r + 64'd512;
            fin_nxt      = 1'b0;
            rnd_nxt      = 6'd0;
            work_nxt     = chain_r;
            state_nxt    = ST_ROUND;
          end
        end else if (in_acc) begin
          // Pad: marker at the tail, zeros after it, length if it fits
          for (int w = 0; w < 16; w++) begin
            for (int b = 0; b < 4; b++) begin
              if ({w[3:0], b[1:0]} == fill_r) begin
                win_nxt[w][(3 - b) * 8 +: 8] = sha_pkg::PAD_BYTE;
              end else if ({w[3:0], b[1:0]} > fill_r) begin
                win_nxt[w][(3 - b) * 8 +: 8] = 8'h00;
              end
            end
          end
          two_blk_nxt = (fill_r >= sha_pkg::LEN_OFFSET);
          if (fill_r < sha_pkg::LEN_OFFSET) begin
            win_nxt[14] = total_now[63:32];
            win_nxt[15] = total_now[31:0];
          end
          total_nxt = total_now;
          fin_nxt   = 1'b1;
          rnd_nxt   = 6'd0;
          work_nxt  = chain_r;
          state_nxt = ST_ROUND;
        end
      end

      ST_ROUND: begin
        work_nxt[7] = work_r[6];
        work_nxt[6] = work_r[5];
        work_nxt[5] = work_r[4];
        work_nxt[4] = work_r[3] + t1;
        work_nxt[3] = work_r[2];
        work_nxt[2] = work_r[1];
        work_nxt[1] = work_r[0];
        work_nxt[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          win_nxt[i] = win_r[i + 1];
        end
        win_nxt[15] = w_new;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = ST_FOLD;
        end
      end

      ST_FOLD: begin
        chain_nxt = fold_sum;
        work_nxt  = fold_sum;
        rnd_nxt   = 6'd0;
        if (fin_r && two_blk_r) begin
          // Length-only block after a spilled tail
          for (int i = 0; i < 14; i++) begin
            win_nxt[i] = '0;
          end
          win_nxt[14] = total_r[63:32];
          win_nxt[15] = total_r[31:0];
          two_blk_nxt = 1'b0;
          state_nxt   = ST_ROUND;
        end else if (fin_r) begin
          widx_nxt  = 3'd0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_OUT: begin
        if (out_acc) begin
          widx_nxt = widx_r + 3'd1;
          if (widx_r == 3'd7) begin
            // Back to the initial state for a new message
            chain_nxt    = sha_pkg::START_H;
            fill_nxt     = 6'd0;
            msg_bits_nxt = 64'd0;
            fin_nxt      = 1'b0;
            two_blk_nxt  = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= 6'd0;
      msg_bits_r <= 64'd0;
      rnd_r      <= 6'd0;
      widx_r     <= 3'd0;
      fin_r      <= 1'b0;
      two_blk_r  <= 1'b0;
      chain_r    <= sha_pkg::START_H;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      msg_bits_r <= msg_bits_nxt;
      rnd_r      <= rnd_nxt;
      widx_r     <= widx_nxt;
      fin_r      <= fin_nxt;
      two_blk_r  <= two_blk_nxt;
      chain_r    <= chain_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    work_r  <= work_nxt;
    win_r   <= win_nxt;
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input accepted while digest pending");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == 6'd63) |=> (state_r == ST_FOLD))
    else $error("round sequence did not end in fold");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_tlast) |=> (in_tready && fill_r == 6'd0 && msg_bits_r == 64'd0))
    else $error("state not restored after digest");

  a_absorb_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0] == sha_pkg::REQ_ABSORB && fill_r != 6'd63) |=> in_tready)
    else $error("absorb of a non-final byte stalled input");

endmodule

// ----- tb/sha256_digest_checker.sv -----
`timescale 1ns / 1ps
// Digest checker for sha256_stream_hasher: keeps its own SHA-256 model of the
// byte stream, predicts the eight digest words per finish and compares them.
// Depends on sha_pkg for the request codes and the word/byte types.
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] req_type
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] digest_word
  input  logic [2:0]  out_tuser,  // [2:0] word_index
  input  logic        out_tlast,  // last_word
  output int          fail_count,
  output int          waiting
);

  typedef struct packed {
    sha_pkg::word_t word;
    logic [2:0]     word_pos;
    logic           last;
  } digest_beat_t;

  // FIPS 180-4 round constants and initial hash value
  localparam sha_pkg::word_t RND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam sha_pkg::word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Model state
  sha_pkg::word_t hash_words [8];
  sha_pkg::byte_t msg_buf [64];
  int unsigned    held;
  logic [63:0]    bit_len;
  digest_beat_t   digest_q [$];

  function automatic sha_pkg::word_t rotr(input sha_pkg::word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of msg_buf into hash_words
  function automatic void fold_block();
    sha_pkg::word_t w [64];
    sha_pkg::word_t v [8];
    sha_pkg::word_t s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_words[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_words[i] = hash_words[i] + v[i];
  endfunction

  function automatic void clear_state();
    for (int i = 0; i < 8; i++) hash_words[i] = IV[i];
    for (int i = 0; i < 64; i++) msg_buf[i] = 8'h00;
    held = 0;
    bit_len = 64'd0;
  endfunction

  function automatic void take_byte(input sha_pkg::byte_t b);
    msg_buf[held] = b;
    held++;
    // full block folds at once
    if (held == 64) begin
      fold_block();
      bit_len = bit_len + 64'd512;
      held = 0;
    end
  endfunction

  // Padding, final block(s), digest words queued, state back to start
  function automatic void close_message();
    logic [63:0]  total;
    int unsigned  p;
    digest_beat_t beat;
    total = bit_len + 64'(held) * 64'd8;
    p = held;
    msg_buf[p] = 8'h80;
    p++;
    // tail of 56 bytes or more: length spills into an extra block
    if (p > 56) begin
      while (p < 64) begin
        msg_buf[p] = 8'h00;
        p++;
      end
      fold_block();
      p = 0;
    end
    while (p < 56) begin
      msg_buf[p] = 8'h00;
      p++;
    end
    for (int i = 0; i < 8; i++) msg_buf[56 + i] = total[63 - 8*i -: 8];
    fold_block();
    for (int i = 0; i < 8; i++) begin
      beat.word     = hash_words[i];
      beat.word_pos = 3'(i);
      beat.last     = (i == 7);
      digest_q.push_back(beat);
    end
    clear_state();
  endfunction

  // Watch both channels
  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (!rst_n) begin
      clear_state();
      digest_q.delete();
      fail_count = 0;
      waiting = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == sha_pkg::REQ_ABSORB) take_byte(in_tdata);
        else close_message();
      end
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest item: word %h index %0d last %b",
                 out_tdata, out_tuser, out_tlast);
          fail_count++;
        end else begin
          exp_beat = digest_q.pop_front();
          if (out_tdata !== exp_beat.word) begin
            $error("digest_word: expected %h, got %h", exp_beat.word, out_tdata);
            fail_count++;
          end
          if (out_tuser !== exp_beat.word_pos) begin
            $error("word_index: expected %0d, got %0d", exp_beat.word_pos, out_tuser);
            fail_count++;
          end
          if (out_tlast !== exp_beat.last) begin
            $error("last_word: expected %b, got %b", exp_beat.last, out_tlast);
            fail_count++;
          end
        end
      end
      waiting = digest_q.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the sha256_stream_hasher testbench: clock, reset, byte-stream stimulus
// with random gaps and output stalls, and the verdict.
// Depends on sha_pkg, sha256_stream_hasher and sha256_digest_checker.
module testbench;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned ITEM_TARGET = 240;  // last message can overshoot to at most 361

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [7:0]  in_tdata = 8'h00;
  logic [0:0]  in_tuser = sha_pkg::REQ_ABSORB;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          waiting;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  logic        burst = 1'b1;
  logic [7:0]  stall_left = 8'd0;
  logic [9:0]  phase = 10'd0;

  sha256_stream_hasher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sha256_digest_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .waiting    (waiting)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Output stalls: short ones mostly, a few long, none begun in every other stretch
  always @(posedge clk) begin
    phase <= phase + 1'b1;
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1'b1;
    end else if (!phase[9] && $urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? 8'($urandom_range(10, 40))
                                                : 8'($urandom_range(0, 2));
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    else if (r < 93) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Message lengths aimed at the padding boundaries and block fills
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 3);
    else if (r < 45) return $urandom_range(4, 54);
    else if (r < 62) return $urandom_range(55, 57);
    else if (r < 75) return $urandom_range(62, 66);
    else if (r < 80) return $urandom_range(118, 121);
    else return $urandom_range(5, 30);
  endfunction

  // Offer one item, return after the first edge at which in_tready reads high
  task automatic send_item(input logic req, input logic [7:0] b);
    int unsigned gap;
    gap = burst ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Sender holds off until every digest word has come out
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    @(posedge clk);
  endtask

  task automatic send_message(input int unsigned len);
    burst = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < len; i++) send_item(sha_pkg::REQ_ABSORB, 8'($urandom));
    // byte on a finish is don't-care, so drive it random
    send_item(sha_pkg::REQ_FINISH, 8'($urandom));
    if ($urandom_range(0, 4) == 0) hold_until_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty messages back to back, byte extremes, short messages
    send_item(sha_pkg::REQ_FINISH, 8'hff);
    send_item(sha_pkg::REQ_FINISH, 8'h00);
    send_item(sha_pkg::REQ_ABSORB, 8'h00);
    send_item(sha_pkg::REQ_ABSORB, 8'hff);
    send_item(sha_pkg::REQ_ABSORB, 8'h80);
    send_item(sha_pkg::REQ_ABSORB, 8'h61);
    send_item(sha_pkg::REQ_FINISH, 8'h00);
    send_item(sha_pkg::REQ_ABSORB, 8'h61);
    send_item(sha_pkg::REQ_ABSORB, 8'h62);
    send_item(sha_pkg::REQ_ABSORB, 8'h63);
    send_item(sha_pkg::REQ_FINISH, 8'h00);
    send_item(sha_pkg::REQ_ABSORB, 8'h55);
    send_item(sha_pkg::REQ_FINISH, 8'haa);
    send_item(sha_pkg::REQ_ABSORB, 8'haa);
    send_item(sha_pkg::REQ_FINISH, 8'h55);
    hold_until_drained();

    // Random messages
    while (items_sent < ITEM_TARGET) send_message(pick_length());

    in_tvalid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (200) @(negedge clk);
    if (fail_count == 0 && waiting == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
